### sv/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg: shared types and codes of the roulette wheel selector
// Holds the command and status codes, the per-cell entry record and the
// control bundle that the top level drives into every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

  // Widths fixed by the item fields
  localparam int HandleW = 32;
  localparam int WeightW = 24;
  localparam int FitW    = 16;
  localparam int FracW   = 17;
  localparam int CntOutW = 9;

  // Fraction value that stands for 1.0
  localparam logic [FracW-1:0] FracOne = 17'h10000;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_PICK   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One table entry: handle and half-open weight interval
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [WeightW-1:0] istart;
    logic [WeightW-1:0] iend;
  } entry_t;

  // Control bundle broadcast to every cell
  typedef struct packed {
    logic               cap_hit;  // capture the interval compare
    logic               cap_sel;  // capture the selection and shift flags
    logic               shift;    // close the gap left by a removal
    logic [WeightW-1:0] point;    // scaled pick point
    logic [WeightW-1:0] rm;       // weight of the removed entry
    entry_t             add_data; // entry written by an add
  } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/rws_cell.sv
// ----------------------------------------------------------------------------
// rws_cell: one entry cell of the selection chain
// Holds one entry, compares its interval end with the pick point, works out
// from its neighbour whether it is the picked entry, and on a removal takes
// over the entry of the next cell with its bounds lowered.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_cell
  import rws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       wr_here,   // an add writes this cell
  input  wire logic       valid,     // this cell holds a live entry
  input  wire logic       valid_nxt, // the next cell holds a live entry
  input  wire logic       prev_hit,  // registered hit of the previous cell
  input  wire entry_t     nxt,       // entry of the next cell
  output logic            hit,
  output entry_t          data,
  output entry_t          msk        // own entry when selected, else zero
);

  logic sel;
  logic shf;
  logic last;

  assign last = valid && !valid_nxt;

  // Control flags: interval compare, then selection and shift marks
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      sel <= 1'b0;
      shf <= 1'b0;
    end else begin
      if (ctrl.cap_hit) begin
        hit <= valid && (data.iend > ctrl.point);
      end
      if (ctrl.cap_sel) begin
        // First entry whose end lies above the point; the last entry if none
        sel <= valid && ((hit && !prev_hit) || (last && !hit));
        shf <= valid && (hit || last);
      end
    end
  end

  // Entry storage: written by an add, shifted down by a removal
  always_ff @(posedge clk) begin
    if (wr_here) begin
      data <= ctrl.add_data;
    end else if (ctrl.shift && shf) begin
      data.handle <= nxt.handle;
      data.istart <= nxt.istart - ctrl.rm;
      data.iend   <= nxt.iend - ctrl.rm;
    end
  end

  assign msk = sel ? data : '0;

endmodule

`default_nettype wire

### sv/rws_reduce.sv
// ----------------------------------------------------------------------------
// rws_reduce: registered first level of the selection gather
// Combines the masked entries of the cells in groups and registers one word
// per group. At most one cell is selected, so an OR acts as a one-hot mux.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_reduce
  import rws_pkg::*;
#(
  parameter int N  = 256,
  parameter int GW = 16,
  parameter int NG = (N + GW - 1) / GW
)(
  input  wire logic   clk,
  input  wire entry_t cells [N],
  output entry_t      grp [NG]
);

  entry_t acc [NG];

  // Per-group OR of the masked cell entries
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      acc[g] = '0;
      for (int j = 0; j < GW; j++) begin
        if (g * GW + j < N) begin
          acc[g] = entry_t'(acc[g] | cells[g * GW + j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp[g] <= acc[g];
    end
  end

endmodule

`default_nettype wire

### sv/roulette_wheel_selector.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selector: fitness-proportionate selection table
// One command is taken while busy is low; its single result appears on the
// result ports for one cycle with done high, and the receiver cannot stall
// it. An add, an error and an unknown command give their result from the
// execute state. A pick runs through the states in order: execute scales
// the fraction by the total in a single multiplier, in compare every cell
// of the chain compares its interval end with the point, select marks the
// picked cell and the cells behind it, group does the registered group
// gather and finish ends it; there a removal shifts the marked cells.
// busy is high from the start transfer until the result cycle, so the next
// command may be given in the cycle in which done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_wheel_selector
  import rws_pkg::*;
#(
  parameter int CAPACITY = 256
)(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic [HandleW-1:0] elt_handle,
  input  wire logic [FitW-1:0]    fitness,
  input  wire logic [FracW-1:0]   rand_frac,
  output logic                    done,
  output logic [HandleW-1:0]      sel_handle,
  output logic [1:0]              status,
  output logic [CntOutW-1:0]      entry_count,
  output logic [WeightW-1:0]      total_weight
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int GW = 16;
  localparam int NG = (CAPACITY + GW - 1) / GW;
  localparam int PW = FracW + WeightW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CMP,
    S_SEL,
    S_GRP,
    S_FIN
  } state_t;

  state_t             state;
  logic [1:0]         cmd_r;
  logic [HandleW-1:0] handle_r;
  logic [FitW-1:0]    fit_r;
  logic [FracW-1:0]   frac_r;
  logic [WeightW-1:0] point;
  logic [CW-1:0]      count;
  logic [WeightW-1:0] weight_total;

  cell_ctrl_t         ctrl;
  logic               write_en;
  logic [WeightW:0]   sum_ext;
  logic [PW-1:0]      prod;
  logic               full;

  logic               valid    [CAPACITY+1];
  logic               hit_prev [CAPACITY+1];
  entry_t             cdata    [CAPACITY+1];
  entry_t             cmsk     [CAPACITY];
  entry_t             grp      [NG];
  entry_t             picked;
  logic [WeightW-1:0] rm;

  // Add arithmetic and pick scaling
  assign sum_ext = {1'b0, weight_total} + {{(WeightW + 1 - FitW){1'b0}}, fit_r};
  assign full    = (count >= CW'(CAPACITY)) || sum_ext[WeightW];
  assign prod    = PW'(frac_r) * PW'(weight_total);

  // Final gather over the group words and the removed weight
  always_comb begin
    picked = '0;
    for (int g = 0; g < NG; g++) begin
      picked = entry_t'(picked | grp[g]);
    end
  end
  assign rm = picked.iend - picked.istart;

  // Control bundle for the cells
  assign write_en         = (state == S_EXEC) && (cmd_r == CMD_ADD) && !full;
  assign ctrl.cap_hit     = (state == S_CMP);
  assign ctrl.cap_sel     = (state == S_SEL);
  assign ctrl.shift       = (state == S_FIN) && (cmd_r == CMD_REMOVE);
  assign ctrl.point       = point;
  assign ctrl.rm          = rm;
  assign ctrl.add_data    = '{handle: handle_r, istart: weight_total,
                              iend: sum_ext[WeightW-1:0]};

  assign valid[CAPACITY]    = 1'b0;
  assign cdata[CAPACITY]    = '0;
  assign hit_prev[0]        = 1'b0;

  // The chain of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    logic wr_here;
    logic hit_c;

    assign valid[i] = Idx < count;
    assign wr_here  = write_en && (count == Idx);

    rws_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .wr_here   (wr_here),
      .valid     (valid[i]),
      .valid_nxt (valid[i+1]),
      .prev_hit  (hit_prev[i]),
      .nxt       (cdata[i+1]),
      .hit       (hit_c),
      .data      (cdata[i]),
      .msk       (cmsk[i])
    );

    if (i + 1 < CAPACITY) begin : g_link
      assign hit_prev[i+1] = hit_c;
    end else begin : g_end
      assign hit_prev[CAPACITY] = hit_c;
    end
  end

  // Registered group gather
  rws_reduce #(
    .N  (CAPACITY),
    .GW (GW),
    .NG (NG)
  ) u_reduce (
    .clk   (clk),
    .cells (cmsk),
    .grp   (grp)
  );

  assign busy         = (state != S_IDLE);
  assign entry_count  = CntOutW'(count);
  assign total_weight = weight_total;

  // Sequencer, table totals and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      weight_total <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd;
            handle_r <= elt_handle;
            fit_r    <= fitness;
            frac_r   <= (rand_frac > FracOne) ? FracOne : rand_frac;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          point <= prod[WeightW+16-1:16];
          if (cmd_r == CMD_ADD) begin
            sel_handle <= '0;
            done       <= 1'b1;
            state      <= S_IDLE;
            if (full) begin
              status <= ST_FULL;
            end else begin
              status       <= ST_OK;
              count        <= count + CW'(1);
              weight_total <= sum_ext[WeightW-1:0];
            end
          end else if (cmd_r == CMD_PICK || cmd_r == CMD_REMOVE) begin
            if (count == '0) begin
              sel_handle <= '0;
              status     <= ST_EMPTY;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              state <= S_CMP;
            end
          end else begin
            sel_handle <= '0;
            status     <= ST_OK;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_CMP: begin
          state <= S_SEL;
        end
        S_SEL: begin
          state <= S_GRP;
        end
        S_GRP: begin
          state <= S_FIN;
        end
        S_FIN: begin
          sel_handle <= picked.handle;
          status     <= ST_OK;
          done       <= 1'b1;
          state      <= S_IDLE;
          if (cmd_r == CMD_REMOVE) begin
            count        <= count - CW'(1);
            weight_total <= weight_total - rm;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
